FILE: rtl/keyboard_report_decoder_defines.svh
// Assertion macros shared by the keyboard report decoder modules.
`ifndef KEYBOARD_REPORT_DECODER_DEFINES_SVH
`define KEYBOARD_REPORT_DECODER_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define KRD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyboard report decoder check failed");

// Next-cycle implication under synchronous reset.
`define KRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyboard report decoder check failed");

`endif

FILE: rtl/krd_pkg.sv
// Shared types, codes and string tables of the keyboard report decoder.
`default_nettype none
package krd_pkg;

   localparam logic [1:0] KIND_REJECTED  = 2'd0;
   localparam logic [1:0] KIND_IDENTITY  = 2'd1;
   localparam logic [1:0] KIND_CAPABILITY = 2'd2;
   localparam logic [1:0] KIND_LIVE      = 2'd3;

   localparam logic [1:0] REG_REPORT_ID   = 2'd0;
   localparam logic [1:0] REG_IDENTITY    = 2'd1;
   localparam logic [1:0] REG_ANALOG      = 2'd2;
   localparam logic [1:0] REG_FULL_SCALE  = 2'd3;

   localparam logic [7:0] PRINT_LOW   = 8'h20;
   localparam logic [7:0] PRINT_HIGH  = 8'h7e;
   localparam logic [7:0] SUB_CAPABILITY = 8'h04;
   localparam logic [7:0] SUB_LIVE    = 8'h01;
   localparam logic [7:0] FIELD_SEP   = 8'h2c;
   localparam logic [9:0] MILLI_FULL  = 10'd1000;

   typedef struct packed {
      logic [7:0] report_id;
      logic [7:0] identity_command;
      logic [7:0] analog_command;
      logic [7:0] full_scale;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       expected_device;
      logic       firmware_known;
      logic [7:0] sensitivity;
      logic [2:0] row;
      logic [4:0] column;
      logic [7:0] travel;
   } job_type;

   function automatic logic [7:0] ctl_char(input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0: r = 8'h4d;
         2'd1: r = 8'h34;
         2'd2: r = 8'h38;
         default: r = 8'h34;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] prod_char(input logic [2:0] idx);
      logic [7:0] r;
      unique case (idx)
         3'd0: r = 8'h58;
         3'd1: r = 8'h38;
         3'd2: r = 8'h36;
         3'd3: r = 8'h48;
         3'd4: r = 8'h45;
         3'd5: r = 8'h52;
         3'd6: r = 8'h47;
         default: r = 8'h42;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] fw_char(input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0: r = 8'h56;
         2'd1: r = 8'h31;
         default: r = 8'h2e;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/krd_front.sv
// Front end: per-byte header capture, identity text scan and report classification.
`default_nettype none
module krd_front #(
   parameter int REPORT_BYTES = 64,
   parameter int ROWS         = 6,
   parameter int COLUMNS      = 22,
   parameter int FIELD_CHARS  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire krd_pkg::cfg_type cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_data,
   input  wire logic             req_last,
   input  wire logic             queue_full,
   output logic                  job_push,
   output krd_pkg::job_type      job
);
   localparam int PW  = $clog2(REPORT_BYTES + 1);
   localparam int FLW = $clog2(FIELD_CHARS + 1);
   localparam logic [PW-1:0]  RB_P  = PW'(REPORT_BYTES);
   localparam logic [7:0]     RB_8  = 8'(REPORT_BYTES);
   localparam logic [FLW-1:0] FC_L  = FLW'(FIELD_CHARS);
   localparam logic [8:0]     ROWS_9 = 9'(ROWS);
   localparam logic [8:0]     COLS_9 = 9'(COLUMNS);

   typedef struct packed {
      logic [2:0]     fnum;
      logic [FLW-1:0] flen;
      logic [2:0]     match;
      logic           fault;
      logic           done;
   } scan_type;

   function automatic scan_type close_field(input scan_type s, input logic terminal);
      scan_type r;
      r = s;
      if (s.fnum >= 3'd6) begin
         r.fault = 1'b1;
         r.done  = 1'b1;
      end else begin
         if (s.fnum == 3'd0) begin
            if (s.flen == '0 || s.flen >= FC_L) r.fault = 1'b1;
            if (s.flen != FLW'(4)) r.match[0] = 1'b0;
         end else if (s.fnum == 3'd4) begin
            if (s.flen == '0 || s.flen >= FC_L) r.fault = 1'b1;
            if (s.flen != FLW'(8)) r.match[1] = 1'b0;
         end else if (s.fnum == 3'd5) begin
            if (s.flen >= FC_L) r.fault = 1'b1;
            if (s.flen < FLW'(3)) r.match[2] = 1'b0;
         end
         r.fnum = s.fnum + 3'd1;
         r.flen = '0;
         if (terminal) begin
            r.done = 1'b1;
            if (r.fnum < 3'd5) r.fault = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic scan_type text_char(input scan_type s, input logic [7:0] c);
      scan_type r;
      logic     checked;
      r = s;
      checked = (s.fnum == 3'd0) || (s.fnum == 3'd4) || (s.fnum == 3'd5);
      if (s.flen < FC_L) r.flen = s.flen + FLW'(1);
      if (checked && (c < krd_pkg::PRINT_LOW || c > krd_pkg::PRINT_HIGH)) r.fault = 1'b1;
      if (s.fnum == 3'd0) begin
         if (s.flen >= FLW'(4) || c != krd_pkg::ctl_char(s.flen[1:0])) r.match[0] = 1'b0;
      end else if (s.fnum == 3'd4) begin
         if (s.flen >= FLW'(8) || c != krd_pkg::prod_char(s.flen[2:0])) r.match[1] = 1'b0;
      end else if (s.fnum == 3'd5) begin
         if (s.flen < FLW'(3) && c != krd_pkg::fw_char(s.flen[1:0])) r.match[2] = 1'b0;
      end
      return r;
   endfunction

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    hdr_ff [8];
   logic [7:0]    col_ff, trav_ff;
   scan_type      scan_ff, scan_in, scan_step;
   logic          accept, in_report, text_on;
   logic [7:0]    len, pos8;
   logic          full, base, is_ident, is_cap, is_live;
   scan_type      scan_clear;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign in_report = pos_ff < RB_P;
   assign len       = hdr_ff[5];
   assign pos8      = 8'(pos_ff);
   assign text_on   = in_report && !scan_ff.done && len > 8'd5 && len < RB_8 &&
                      pos8 >= 8'd6 && pos8 <= len;

   always_comb begin
      scan_clear = '{fnum: 3'd0, flen: '0, match: 3'b111, fault: 1'b0, done: 1'b0};
      scan_step = scan_ff;
      if (text_on) begin
         if (req_data == 8'd0)                      scan_step = close_field(scan_ff, 1'b1);
         else if (req_data == krd_pkg::FIELD_SEP)   scan_step = close_field(scan_ff, 1'b0);
         else                                       scan_step = text_char(scan_ff, req_data);
         if (pos8 == len && !scan_step.done)        scan_step = close_field(scan_step, 1'b1);
      end
   end

   // Verdict on the final byte; the header bytes are all stored by then.
   assign full     = (9'(pos_ff) + 9'd1) >= 9'(REPORT_BYTES);
   assign base     = full && hdr_ff[0] == cfg.report_id;
   assign is_ident = base && hdr_ff[1] == cfg.identity_command && hdr_ff[2] == 8'd0 &&
                     hdr_ff[4] == 8'd0 && len > 8'd5 && len < RB_8 &&
                     scan_step.done && !scan_step.fault;
   assign is_cap   = base && hdr_ff[1] == cfg.analog_command && len >= 8'd2 &&
                     hdr_ff[6] == krd_pkg::SUB_CAPABILITY && hdr_ff[7] <= cfg.full_scale;
   assign is_live  = base && hdr_ff[1] == cfg.analog_command && len >= 8'd3 &&
                     hdr_ff[6] == krd_pkg::SUB_LIVE && {1'b0, hdr_ff[7]} < ROWS_9 &&
                     {1'b0, col_ff} < COLS_9;

   always_comb begin
      job = '0;
      priority if (is_ident) begin
         job.kind            = krd_pkg::KIND_IDENTITY;
         job.expected_device = scan_step.match[0] && scan_step.match[1];
         job.firmware_known  = scan_step.match[2];
      end else if (is_cap) begin
         job.kind        = krd_pkg::KIND_CAPABILITY;
         job.sensitivity = hdr_ff[7];
      end else if (is_live) begin
         job.kind   = krd_pkg::KIND_LIVE;
         job.row    = hdr_ff[7][2:0];
         job.column = col_ff[4:0];
         job.travel = trav_ff;
      end else begin
         job.kind = krd_pkg::KIND_REJECTED;
      end
   end

   assign job_push = accept && req_last;

   always_comb begin
      pos_in  = pos_ff;
      scan_in = scan_ff;
      if (accept) begin
         if (in_report) pos_in = pos_ff + PW'(1);
         scan_in = scan_step;
         if (req_last) begin
            pos_in  = '0;
            scan_in = scan_clear;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         scan_ff <= '{fnum: 3'd0, flen: '0, match: 3'b111, fault: 1'b0, done: 1'b0};
         for (int k = 0; k < 8; k++) hdr_ff[k] <= 8'd0;
         col_ff  <= 8'd0;
         trav_ff <= 8'd0;
      end else begin
         pos_ff  <= pos_in;
         scan_ff <= scan_in;
         if (accept && req_last) begin
            for (int k = 0; k < 8; k++) hdr_ff[k] <= 8'd0;
            col_ff  <= 8'd0;
            trav_ff <= 8'd0;
         end else if (accept && in_report) begin
            if (pos8 < 8'd8) hdr_ff[pos_ff[2:0]] <= req_data;
            else if (pos8 == 8'd8) col_ff <= req_data;
            else if (pos8 == 8'd9) trav_ff <= req_data;
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/krd_queue.sv
// Two-entry queue of classified reports between the front and back ends.
`default_nettype none
`include "keyboard_report_decoder_defines.svh"
module krd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire krd_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output krd_pkg::job_type      pop_data,
   output logic                  empty
);
   krd_pkg::job_type entry_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) entry_ff[wr_ff] <= push_data;
   end

   `KRD_ASSERT_NOW(a_no_push_full, clock, reset, full, !push)
   `KRD_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)
   `KRD_ASSERT_NOW(a_ptr_match, clock, reset, empty || full, wr_ff == rd_ff)
endmodule
`default_nettype wire

FILE: rtl/krd_back.sv
// Back end: travel scaling by restoring division and the result register.
`default_nettype none
`include "keyboard_report_decoder_defines.svh"
module krd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       full_scale,
   input  wire logic             job_ready,
   input  wire krd_pkg::job_type job,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic                  rsp_expected_device,
   output logic                  rsp_firmware_known,
   output logic [7:0]            rsp_sensitivity,
   output logic [2:0]            rsp_row,
   output logic [4:0]            rsp_column,
   output logic [7:0]            rsp_travel,
   output logic [9:0]            rsp_travel_milli
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   krd_pkg::job_type job_ff;
   logic [17:0]      rem_ff, rem_in, dvs_ff, dvs_in;
   logic [9:0]       q_ff, q_in;
   logic [3:0]       step_ff, step_in;
   logic [7:0]       fsz;
   logic             ge;

   assign fsz     = (full_scale == 8'd0) ? 8'd1 : full_scale;
   assign job_pop = state_ff == ST_IDLE && job_ready;
   assign ge      = rem_ff >= dvs_ff;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               q_in    = 10'd0;
               rem_in  = 18'(job.travel) * 18'd1000 + 18'(fsz[7:1]);
               dvs_in  = {1'b0, fsz, 9'd0};
               step_in = 4'd9;
               if (job.kind != krd_pkg::KIND_LIVE) begin
                  state_in = ST_OUT;
               end else if (job.travel >= fsz) begin
                  q_in     = krd_pkg::MILLI_FULL;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            q_in    = {q_ff[8:0], ge};
            rem_in  = ge ? rem_ff - dvs_ff : rem_ff;
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      if (job_pop) job_ff <= job;
   end

   assign rsp_valid           = state_ff == ST_OUT;
   assign rsp_kind            = job_ff.kind;
   assign rsp_expected_device = job_ff.expected_device;
   assign rsp_firmware_known  = job_ff.firmware_known;
   assign rsp_sensitivity     = job_ff.sensitivity;
   assign rsp_row             = job_ff.row;
   assign rsp_column          = job_ff.column;
   assign rsp_travel          = job_ff.travel;
   assign rsp_travel_milli    = q_ff;

   `KRD_ASSERT_NOW(a_milli_cap, clock, reset, rsp_valid, rsp_travel_milli <= 10'd1000)
   `KRD_ASSERT_NOW(a_milli_live, clock, reset,
      rsp_valid && rsp_kind != krd_pkg::KIND_LIVE, rsp_travel_milli == 10'd0)
   `KRD_ASSERT_NEXT(a_div_ends, clock, reset,
      state_ff == ST_DIV && step_ff == 4'd0, state_ff == ST_OUT)
endmodule
`default_nettype wire

FILE: rtl/keyboard_report_decoder.sv
// Top level of the keyboard report decoder: register file, front end, queue and back end.
//
// Usage: report bytes enter on the req_ channel (req_data, req_last marks the final
// byte), one per accepted request, byte zero first. Each report yields exactly one
// verdict on the rsp_ channel after its final byte; other bytes yield nothing.
// The front end takes one byte per cycle while the queue is not full and classifies
// the report when the final byte arrives; the verdict enters a two-entry queue. The
// back end then moves rejected, identity, capability and saturated live verdicts
// straight to its output register, and runs a live verdict that needs scaling through
// the ten steps of its restoring divider first, before the verdict shows on rsp_.
// If the receiver stalls, the verdict holds in the output register and up to two
// more verdicts wait in the queue; only when the queue is full does req_ready drop.
// Synchronous reset clears the report state, the queue and the back end, and sets
// the registers to report id 0, both commands 0 and full scale 255.
// Registers are written over the APB-style port at byte addresses 0, 4, 8 and 12.
`default_nettype none
module keyboard_report_decoder #(
   parameter int REPORT_BYTES = 64,
   parameter int ROWS         = 6,
   parameter int COLUMNS      = 22,
   parameter int FIELD_CHARS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic             rsp_expected_device,
   output logic             rsp_firmware_known,
   output logic [7:0]       rsp_sensitivity,
   output logic [2:0]       rsp_row,
   output logic [4:0]       rsp_column,
   output logic [7:0]       rsp_travel,
   output logic [9:0]       rsp_travel_milli
);
   krd_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_idx;
   logic             queue_full, queue_empty, job_push, job_pop;
   krd_pkg::job_type push_job, pop_job;

   // Register file; the write completes in the access phase.
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{report_id: 8'd0, identity_command: 8'd0,
                     analog_command: 8'd0, full_scale: 8'd255};
      end else if (wr_en) begin
         unique case (reg_idx)
            krd_pkg::REG_REPORT_ID:  cfg_ff.report_id        <= pwdata[7:0];
            krd_pkg::REG_IDENTITY:   cfg_ff.identity_command <= pwdata[7:0];
            krd_pkg::REG_ANALOG:     cfg_ff.analog_command   <= pwdata[7:0];
            krd_pkg::REG_FULL_SCALE: cfg_ff.full_scale       <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         krd_pkg::REG_REPORT_ID:  prdata = {24'd0, cfg_ff.report_id};
         krd_pkg::REG_IDENTITY:   prdata = {24'd0, cfg_ff.identity_command};
         krd_pkg::REG_ANALOG:     prdata = {24'd0, cfg_ff.analog_command};
         krd_pkg::REG_FULL_SCALE: prdata = {24'd0, cfg_ff.full_scale};
         default:                 prdata = 32'd0;
      endcase
   end

   krd_front #(
      .REPORT_BYTES(REPORT_BYTES),
      .ROWS(ROWS),
      .COLUMNS(COLUMNS),
      .FIELD_CHARS(FIELD_CHARS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .req_last(req_last),
      .queue_full(queue_full),
      .job_push(job_push),
      .job(push_job)
   );

   krd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(push_job),
      .full(queue_full),
      .pop(job_pop),
      .pop_data(pop_job),
      .empty(queue_empty)
   );

   krd_back u_back (
      .clock(clock),
      .reset(reset),
      .full_scale(cfg_ff.full_scale),
      .job_ready(!queue_empty),
      .job(pop_job),
      .job_pop(job_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_expected_device(rsp_expected_device),
      .rsp_firmware_known(rsp_firmware_known),
      .rsp_sensitivity(rsp_sensitivity),
      .rsp_row(rsp_row),
      .rsp_column(rsp_column),
      .rsp_travel(rsp_travel),
      .rsp_travel_milli(rsp_travel_milli)
   );
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the keyboard report decoder: directed and random reports.
`timescale 1ns / 1ps
module testbench;

   // Geometry of the block as built with its default parameters.
   localparam int REPORT_LEN  = 64;
   localparam int ROW_COUNT   = 6;
   localparam int COL_COUNT   = 22;
   localparam int TEXT_LIMIT  = 16;
   localparam int MAX_FIELDS  = 6;
   localparam int DRAIN_CYCLES = 40;

   // Bits of the string match flags kept while an identity text is scanned.
   localparam logic [2:0] HIT_CTL  = 3'b001;
   localparam logic [2:0] HIT_PROD = 3'b010;
   localparam logic [2:0] HIT_FW   = 3'b100;

   // Expected controller, product and firmware strings, held as byte codes.
   localparam logic [7:0] CTL_STR [4]  = '{8'h4d, 8'h34, 8'h38, 8'h34};
   localparam logic [7:0] PROD_STR [8] = '{8'h58, 8'h38, 8'h36, 8'h48,
                                           8'h45, 8'h52, 8'h47, 8'h42};
   localparam logic [7:0] FW_STR [3]   = '{8'h56, 8'h31, 8'h2e};

   typedef struct packed {
      logic [1:0] kind;
      logic       expected_device;
      logic       firmware_known;
      logic [7:0] sensitivity;
      logic [2:0] row;
      logic [4:0] column;
      logic [7:0] travel;
      logic [9:0] travel_milli;
   } verdict_type;

   typedef logic [7:0] byte_q_type[$];

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic        rsp_expected_device;
   logic        rsp_firmware_known;
   logic [7:0]  rsp_sensitivity;
   logic [2:0]  rsp_row;
   logic [4:0]  rsp_column;
   logic [7:0]  rsp_travel;
   logic [9:0]  rsp_travel_milli;

   keyboard_report_decoder DUT (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind), .rsp_expected_device(rsp_expected_device),
      .rsp_firmware_known(rsp_firmware_known),
      .rsp_sensitivity(rsp_sensitivity), .rsp_row(rsp_row),
      .rsp_column(rsp_column), .rsp_travel(rsp_travel),
      .rsp_travel_milli(rsp_travel_milli)
   );

   // The clock runs at 50 MHz.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------------
   // Decoder mirror: configuration plus the per-report parse state.
   // ---------------------------------------------------------------------
   logic [7:0] cfg_report_id;
   logic [7:0] cfg_identity_cmd;
   logic [7:0] cfg_analog_cmd;
   logic [7:0] cfg_full_scale;

   int         byte_pos;
   logic [7:0] head [8];
   logic [7:0] live_col;
   logic [7:0] live_trav;
   int         field_idx;
   int         field_len;
   logic [2:0] hit_flags;
   logic       bad_text;
   logic       text_done;

   verdict_type expected_verdicts[$];
   int         failures;
   int         mismatches;
   int         hold_left;

   function automatic void clear_report_state();
      byte_pos  = 0;
      foreach (head[k]) head[k] = 8'h00;
      live_col  = 8'h00;
      live_trav = 8'h00;
      field_idx = 0;
      field_len = 0;
      hit_flags = HIT_CTL | HIT_PROD | HIT_FW;
      bad_text  = 1'b0;
      text_done = 1'b0;
   endfunction

   // Closes the field being scanned; a terminal close also ends the text.
   function automatic void end_field(input bit terminal);
      if (field_idx >= MAX_FIELDS) begin
         bad_text  = 1'b1;
         text_done = 1'b1;
         return;
      end
      if (field_idx == 0) begin
         if (field_len == 0 || field_len >= TEXT_LIMIT) bad_text = 1'b1;
         if (field_len != 4) hit_flags &= ~HIT_CTL;
      end else if (field_idx == 4) begin
         if (field_len == 0 || field_len >= TEXT_LIMIT) bad_text = 1'b1;
         if (field_len != 8) hit_flags &= ~HIT_PROD;
      end else if (field_idx == 5) begin
         if (field_len >= TEXT_LIMIT) bad_text = 1'b1;
         if (field_len < 3) hit_flags &= ~HIT_FW;
      end
      field_idx++;
      field_len = 0;
      if (terminal) begin
         text_done = 1'b1;
         if (field_idx < 5) bad_text = 1'b1;
      end
   endfunction

   function automatic void scan_char(input logic [7:0] c);
      int pos;
      pos = field_len;
      if (field_len < TEXT_LIMIT) field_len++;
      if ((field_idx == 0 || field_idx == 4 || field_idx == 5) &&
          (c < krd_pkg::PRINT_LOW || c > krd_pkg::PRINT_HIGH)) bad_text = 1'b1;
      if (field_idx == 0) begin
         if (pos >= 4 || c != CTL_STR[pos]) hit_flags &= ~HIT_CTL;
      end else if (field_idx == 4) begin
         if (pos >= 8 || c != PROD_STR[pos]) hit_flags &= ~HIT_PROD;
      end else if (field_idx == 5) begin
         if (pos < 3 && c != FW_STR[pos]) hit_flags &= ~HIT_FW;
      end
   endfunction

   function automatic logic [9:0] scale_travel(input logic [7:0] t);
      int fs;
      int v;
      fs = (cfg_full_scale == 8'd0) ? 1 : int'(cfg_full_scale);
      v  = (int'(t) * 1000 + fs / 2) / fs;
      return (v > 1000) ? krd_pkg::MILLI_FULL : v[9:0];
   endfunction

   // Advances the mirror by one accepted request and queues the verdict it causes.
   function automatic void predict_request(input logic [7:0] c, input logic fin);
      int       idx;
      int       tlen;
      bit       whole;
      bit       base;
      verdict_type v;
      idx = byte_pos;
      v   = '0;
      if (idx < REPORT_LEN) begin
         if (idx < 8) head[idx] = c;
         else if (idx == 8) live_col = c;
         else if (idx == 9) live_trav = c;
         tlen = head[5];
         if (!text_done && tlen > 5 && tlen < REPORT_LEN && idx >= 6 && idx <= tlen) begin
            if (c == 8'h00) end_field(1'b1);
            else if (c == krd_pkg::FIELD_SEP) end_field(1'b0);
            else scan_char(c);
            if (idx == tlen && !text_done) end_field(1'b1);
         end
         byte_pos = idx + 1;
      end
      if (!fin) return;
      whole = (idx + 1 >= REPORT_LEN);
      base  = whole && head[0] == cfg_report_id;
      tlen  = head[5];
      if (base && head[1] == cfg_identity_cmd && head[2] == 8'h00 && head[4] == 8'h00 &&
          tlen > 5 && tlen < REPORT_LEN && text_done && !bad_text) begin
         v.kind            = krd_pkg::KIND_IDENTITY;
         v.expected_device = (hit_flags & (HIT_CTL | HIT_PROD)) == (HIT_CTL | HIT_PROD);
         v.firmware_known  = (hit_flags & HIT_FW) != 3'b000;
      end else if (base && head[1] == cfg_analog_cmd && tlen >= 2 &&
                   head[6] == krd_pkg::SUB_CAPABILITY && head[7] <= cfg_full_scale) begin
         v.kind        = krd_pkg::KIND_CAPABILITY;
         v.sensitivity = head[7];
      end else if (base && head[1] == cfg_analog_cmd && tlen >= 3 &&
                   head[6] == krd_pkg::SUB_LIVE && head[7] < ROW_COUNT &&
                   live_col < COL_COUNT) begin
         v.kind         = krd_pkg::KIND_LIVE;
         v.row          = head[7][2:0];
         v.column       = live_col[4:0];
         v.travel       = live_trav;
         v.travel_milli = scale_travel(live_trav);
      end else begin
         v.kind = krd_pkg::KIND_REJECTED;
      end
      expected_verdicts.push_back(v);
      clear_report_state();
   endfunction

   // ---------------------------------------------------------------------
   // Drivers.
   // ---------------------------------------------------------------------

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sends one request and waits for its acceptance; valid stays up between
   // back-to-back requests and only drops for an idle gap.
   task automatic send_request(input logic [7:0] d, input logic fin);
      int gap;
      req_valid = 1'b1;
      req_data  = d;
      req_last  = fin;
      do @(posedge clock); while (!req_ready);
      predict_request(d, fin);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         req_data  = 8'($urandom_range(0, 255));
         req_last  = 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_report(input byte_q_type rpt);
      foreach (rpt[k]) send_request(rpt[k], k == rpt.size() - 1);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = {24'h0, val};
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      case (idx)
         krd_pkg::REG_REPORT_ID:  cfg_report_id    = val;
         krd_pkg::REG_IDENTITY:   cfg_identity_cmd = val;
         krd_pkg::REG_ANALOG:     cfg_analog_cmd   = val;
         krd_pkg::REG_FULL_SCALE: cfg_full_scale   = val;
         default: ;
      endcase
   endtask

   // Registers are only touched once every verdict is out and the back end
   // has had time to finish a scaling pass.
   task automatic configure(input logic [7:0] rid, input logic [7:0] icmd,
                            input logic [7:0] acmd, input logic [7:0] fs);
      req_valid = 1'b0;
      wait (expected_verdicts.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_reg(krd_pkg::REG_REPORT_ID, rid);
      write_reg(krd_pkg::REG_IDENTITY, icmd);
      write_reg(krd_pkg::REG_ANALOG, acmd);
      write_reg(krd_pkg::REG_FULL_SCALE, fs);
   endtask

   // ---------------------------------------------------------------------
   // Report builders.
   // ---------------------------------------------------------------------
   function automatic logic [7:0] text_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 126)); while (c == krd_pkg::FIELD_SEP);
      return c;
   endfunction

   function automatic void add_random_text(ref byte_q_type q, input int n);
      repeat (n) q.push_back(text_byte());
   endfunction

   // Pads to full length with random bytes, then cuts or stretches the
   // report when a short or long report is wanted.
   function automatic void finish_report(ref byte_q_type q, input bit odd_size);
      int n;
      while (q.size() < REPORT_LEN) q.push_back(8'($urandom_range(0, 255)));
      if (odd_size) begin
         if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, REPORT_LEN - 1);
            while (q.size() > n) void'(q.pop_back());
         end else begin
            repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Builds an identity response; without clean, strings vary and one
   // random defect may be planted.
   function automatic byte_q_type make_identity(input bit clean, input int fw_mode);
      byte_q_type q;
      byte_q_type txt;
      int      k;
      if (clean || $urandom_range(0, 2) != 0) foreach (CTL_STR[j]) txt.push_back(CTL_STR[j]);
      else add_random_text(txt, $urandom_range(0, 17));
      for (k = 0; k < 3; k++) begin
         txt.push_back(krd_pkg::FIELD_SEP);
         add_random_text(txt, $urandom_range(0, 4));
      end
      txt.push_back(krd_pkg::FIELD_SEP);
      if (clean || $urandom_range(0, 2) != 0) foreach (PROD_STR[j]) txt.push_back(PROD_STR[j]);
      else add_random_text(txt, $urandom_range(0, 17));
      if (fw_mode == 1) begin
         txt.push_back(krd_pkg::FIELD_SEP);
         foreach (FW_STR[j]) txt.push_back(FW_STR[j]);
         add_random_text(txt, $urandom_range(0, 4));
      end else if (fw_mode == 2) begin
         txt.push_back(krd_pkg::FIELD_SEP);
         add_random_text(txt, $urandom_range(0, 17));
      end
      if (!clean) begin
         case ($urandom_range(0, 4))
            0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            1: txt.insert($urandom_range(0, txt.size()), krd_pkg::FIELD_SEP);
            2: txt.insert($urandom_range(0, txt.size()), 8'h00);
            default: ;
         endcase
      end
      while (txt.size() > REPORT_LEN - 7) void'(txt.pop_back());
      q = '{cfg_report_id, cfg_identity_cmd, 8'h00, 8'($urandom_range(0, 255)), 8'h00,
            8'(txt.size() + 5)};
      if (!clean) begin
         case ($urandom_range(0, 9))
            0: q[2] = 8'($urandom_range(1, 255));
            1: q[4] = 8'($urandom_range(1, 255));
            2: q[5] = 8'($urandom_range(0, 255));
            3: q[0] = 8'($urandom_range(0, 255));
            default: ;
         endcase
      end
      foreach (txt[j]) q.push_back(txt[j]);
      if (!clean && $urandom_range(0, 1)) q.push_back(8'h00);
      finish_report(q, !clean && $urandom_range(0, 9) == 0);
      return q;
   endfunction

   function automatic byte_q_type make_capability(input logic [7:0] sens, input bit noisy);
      byte_q_type q;
      q = '{cfg_report_id, cfg_analog_cmd, 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(2, 255)), krd_pkg::SUB_CAPABILITY, sens};
      if (noisy) begin
         case ($urandom_range(0, 5))
            0: q[5] = 8'($urandom_range(0, 1));
            1: q[6] = 8'($urandom_range(0, 255));
            2: q[0] = 8'($urandom_range(0, 255));
            default: ;
         endcase
      end
      finish_report(q, noisy && $urandom_range(0, 9) == 0);
      return q;
   endfunction

   function automatic byte_q_type make_live(input logic [7:0] r, input logic [7:0] col,
                                            input logic [7:0] trav, input bit noisy);
      byte_q_type q;
      q = '{cfg_report_id, cfg_analog_cmd, 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(3, 255)), krd_pkg::SUB_LIVE, r, col, trav};
      if (noisy) begin
         case ($urandom_range(0, 5))
            0: q[5] = 8'($urandom_range(0, 2));
            1: q[6] = 8'($urandom_range(0, 255));
            2: q[1] = 8'($urandom_range(0, 255));
            default: ;
         endcase
      end
      finish_report(q, noisy && $urandom_range(0, 9) == 0);
      return q;
   endfunction

   function automatic byte_q_type make_noise();
      byte_q_type q;
      finish_report(q, $urandom_range(0, 3) == 0);
      foreach (q[k]) q[k] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) q[0] = cfg_report_id;
      return q;
   endfunction

   function automatic logic [7:0] pick_row();
      return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, ROW_COUNT - 1));
   endfunction

   function automatic logic [7:0] pick_col();
      return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, COL_COUNT - 1));
   endfunction

   // One random report of any kind, mostly well formed.
   function automatic byte_q_type make_any_report();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return make_identity($urandom_range(0, 2) == 0, $urandom_range(0, 2));
      if (r < 5) return make_capability(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, cfg_full_scale)),
                                         $urandom_range(0, 2) == 0);
      if (r < 8) return make_live(pick_row(), pick_col(), 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 2) == 0);
      return make_noise();
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random stalls plus a long hold-off counted down on its own.
   // ---------------------------------------------------------------------
   int stall_left;

   always @(negedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
   end

   // Every verdict is matched, field by field, against the oldest expectation.
   always @(posedge clock) begin
      verdict_type seen;
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_kind, rsp_expected_device, rsp_firmware_known, rsp_sensitivity,
                  rsp_row, rsp_column, rsp_travel, rsp_travel_milli};
         if (expected_verdicts.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict: kind %0d", seen.kind);
         end else begin
            want = expected_verdicts.pop_front();
            if (seen.kind !== want.kind || seen.expected_device !== want.expected_device ||
                seen.firmware_known !== want.firmware_known ||
                seen.sensitivity !== want.sensitivity || seen.row !== want.row ||
                seen.column !== want.column || seen.travel !== want.travel ||
                seen.travel_milli !== want.travel_milli) begin
               failures++;
               mismatches++;
               if (mismatches <= 10)
                  $display("verdict mismatch: expected kind %0d dev %0d fw %0d sens %0d ",
                           "row %0d col %0d trav %0d milli %0d, ",
                           "got kind %0d dev %0d fw %0d sens %0d ",
                           "row %0d col %0d trav %0d milli %0d",
                           want.kind, want.expected_device, want.firmware_known,
                           want.sensitivity, want.row, want.column, want.travel,
                           want.travel_milli, seen.kind, seen.expected_device,
                           seen.firmware_known, seen.sensitivity, seen.row, seen.column,
                           seen.travel, seen.travel_milli);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Well-formed identity reports with and without a known firmware field.
   task automatic test_identity();
      configure(8'h00, 8'hff, 8'h11, 8'hff);
      send_report(make_identity(1'b1, 1));
      send_report(make_identity(1'b1, 0));
      send_report(make_identity(1'b1, 2));
      configure(8'hff, 8'h00, 8'h80, 8'h01);
      send_report(make_identity(1'b1, 1));
   endtask

   // Sensitivity at zero, at full scale and just above it.
   task automatic test_capability();
      configure(8'h5a, 8'h22, 8'h33, 8'd200);
      send_report(make_capability(8'd0, 1'b0));
      send_report(make_capability(8'd200, 1'b0));
      send_report(make_capability(8'd201, 1'b0));
   endtask

   // Live events at the row, column and travel extremes, with the smallest,
   // largest and a zero full scale.
   task automatic test_live();
      configure(8'h01, 8'h02, 8'h03, 8'd255);
      send_report(make_live(8'd0, 8'd0, 8'd0, 1'b0));
      send_report(make_live(8'd5, 8'd21, 8'd255, 1'b0));
      send_report(make_live(8'd6, 8'd3, 8'd9, 1'b0));
      send_report(make_live(8'd2, 8'd22, 8'd9, 1'b0));
      configure(8'h01, 8'h02, 8'h03, 8'd1);
      send_report(make_live(8'd1, 8'd7, 8'd1, 1'b0));
      configure(8'h01, 8'h02, 8'h03, 8'd0);
      send_report(make_live(8'd4, 8'd10, 8'd128, 1'b0));
      configure(8'h01, 8'h02, 8'h03, 8'd3);
      send_report(make_live(8'd3, 8'd1, 8'd1, 1'b0));
      send_report(make_live(8'd3, 8'd1, 8'd2, 1'b0));
   endtask

   // Short, long and garbled reports.
   task automatic test_malformed();
      byte_q_type q;
      configure(8'h07, 8'h10, 8'h20, 8'd100);
      q = make_capability(8'd10, 1'b0);
      void'(q.pop_back());
      send_report(q);
      q = make_live(8'd1, 8'd1, 8'd50, 1'b0);
      q.push_back(8'hff);
      q.push_back(8'h00);
      send_report(q);
      send_report(make_noise());
      send_report(make_identity(1'b0, 2));
   endtask

   // With both commands equal, identity wins over capability over live.
   task automatic test_equal_commands();
      configure(8'h42, 8'h42, 8'h42, 8'd255);
      repeat (3) send_report(make_any_report());
   endtask

   // The receiver holds off long enough for the queue to fill and the
   // request side to stall.
   task automatic test_backpressure();
      configure(8'h10, 8'h21, 8'h32, 8'd127);
      hold_left = 600;
      repeat (6) send_report(make_live(pick_row(), pick_col(), 8'($urandom_range(0, 255)),
                                       1'b0));
   endtask

   task automatic test_random();
      int phase;
      for (phase = 0; phase < 2; phase++) begin
         configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         repeat (2) send_report(make_any_report());
      end
   endtask

   initial begin
      reset     = 1'b1;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      req_valid = 1'b0;
      req_data  = '0;
      req_last  = 1'b0;
      rsp_ready = 1'b0;
      failures  = 0;
      mismatches = 0;
      hold_left = 0;
      stall_left = 0;
      cfg_report_id    = 8'h00;
      cfg_identity_cmd = 8'h00;
      cfg_analog_cmd   = 8'h00;
      cfg_full_scale   = 8'hff;
      clear_report_state();
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_identity();
      test_capability();
      test_live();
      test_malformed();
      test_equal_commands();
      test_backpressure();
      test_random();
      req_valid = 1'b0;
      wait (expected_verdicts.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("[keyboard_report_decoder] OK");
      end else begin
         $display("[keyboard_report_decoder] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4ms;
      $display("[keyboard_report_decoder] ERROR");
      $finish;
   end

endmodule
